// ===== src/rcc_pkg.sv =====
// ----------------------------------------------------------------------------
// rcc_pkg: shared types and constants of the RC oscillator calibrator
// Holds the calibration phase codes, the state record and the search constants.
// ----------------------------------------------------------------------------
package rcc_pkg;

    // calibration phase
    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_BINARY = 3'd1,
        PH_NEIGH  = 3'd2,
        PH_DONE   = 3'd3
    } t_phase;

    // search state carried from one measurement to the next
    typedef struct packed {
        t_phase      phase;
        logic        upper_half;
        logic [7:0]  step_size;
        logic [7:0]  trial_base;
        logic [8:0]  neighbour_value;
        logic [7:0]  best_value;
        logic [15:0] best_deviation;
        logic [7:0]  lower_value;
        logic [15:0] lower_deviation;
    } t_state;

    // input action codes
    localparam logic ACT_START   = 1'b0;
    localparam logic ACT_MEASURE = 1'b1;

    // register index decoded from the bus address
    localparam logic REG_TARGET = 1'b0;

    localparam logic [15:0] C_TARGET_RESET = 16'd2750;
    localparam logic [7:0]  C_STEP_INIT    = 8'h40;
    localparam logic [7:0]  C_LOWER_BASE   = 8'h00;
    localparam logic [7:0]  C_UPPER_BASE   = 8'h80;
    localparam logic [7:0]  C_TRIM_MAX     = 8'hFF;
    localparam logic [15:0] C_DEV_INIT     = 16'h00FF;

endpackage

// ===== src/rcc_step.sv =====
// ----------------------------------------------------------------------------
// rcc_step: next-state and result logic for one measurement
// Runs the binary search, the neighbour search and the final choice between
// the lower and upper halves for a single transaction.
// ----------------------------------------------------------------------------
module rcc_step (
    input  rcc_pkg::t_state i_state,
    input  logic            i_action,
    input  logic [15:0]     i_frame_length,
    input  logic [15:0]     i_target,
    output rcc_pkg::t_state o_state,
    output logic            o_emit,
    output logic [7:0]      o_trim_value,
    output logic            o_finished
);
    import rcc_pkg::*;

    t_state      n_st;
    logic        w_below;
    logic        w_fail;
    logic [7:0]  w_base;
    logic [7:0]  w_step;
    logic [15:0] w_dev;
    logic [8:0]  w_next_nb;
    logic [8:0]  w_last;
    logic        w_finish;

    assign w_below = i_frame_length < i_target;
    assign w_fail  = i_frame_length == 16'd0;
    assign w_dev   = w_below ? (i_target - i_frame_length) : (i_frame_length - i_target);

    always_comb begin
        n_st         = i_state;
        o_emit       = 1'b0;
        o_trim_value = 8'd0;
        o_finished   = 1'b0;
        w_finish     = 1'b0;
        w_base       = i_state.trial_base;
        w_step       = i_state.step_size;
        w_next_nb    = 9'((i_state.neighbour_value + 9'd1) & 9'h1FF);
        w_last       = (i_state.trial_base == C_TRIM_MAX) ? {1'b0, C_TRIM_MAX}
                                                          : {1'b0, i_state.trial_base} + 9'd1;

        if (i_action == ACT_START) begin
            // restart from the lower half
            n_st.upper_half = 1'b0;
            n_st.trial_base = C_LOWER_BASE;
            n_st.step_size  = C_STEP_INIT;
            n_st.phase      = PH_BINARY;
            o_emit          = 1'b1;
            o_trim_value    = C_LOWER_BASE + C_STEP_INIT;
        end else begin
            unique case (i_state.phase)
                PH_BINARY: begin
                    if (w_fail) begin
                        // failed measurement: the half ends with trim zero
                        n_st.best_value     = 8'd0;
                        n_st.best_deviation = 16'd0;
                        w_finish            = 1'b1;
                    end else begin
                        // raise the base when the oscillator runs slow
                        w_base = w_below ? i_state.trial_base + i_state.step_size
                                         : i_state.trial_base;
                        w_step = {1'b0, i_state.step_size[7:1]};
                        n_st.trial_base = w_base;
                        n_st.step_size  = w_step;
                        o_emit          = 1'b1;
                        if (w_step != 8'd0) begin
                            o_trim_value = w_base + w_step;
                        end else begin
                            // enter the neighbour search at base minus one
                            n_st.best_value      = w_base;
                            n_st.best_deviation  = C_DEV_INIT;
                            n_st.neighbour_value = (w_base == 8'd0) ? 9'd0
                                                                    : {1'b0, w_base - 8'd1};
                            n_st.phase           = PH_NEIGH;
                            o_trim_value         = n_st.neighbour_value[7:0];
                        end
                    end
                end
                PH_NEIGH: begin
                    if (w_fail) begin
                        w_finish = 1'b1;
                    end else begin
                        // keep the strictly better neighbour
                        if (w_dev < i_state.best_deviation) begin
                            n_st.best_deviation = w_dev;
                            n_st.best_value     = i_state.neighbour_value[7:0];
                        end
                        n_st.neighbour_value = w_next_nb;
                        if (w_next_nb <= w_last) begin
                            o_emit       = 1'b1;
                            o_trim_value = w_next_nb[7:0];
                        end else begin
                            w_finish = 1'b1;
                        end
                    end
                end
                PH_DONE: begin
                    o_emit       = 1'b1;
                    o_trim_value = i_state.best_value;
                    o_finished   = 1'b1;
                end
                default: begin
                    // idle: measurement gives no result
                end
            endcase

            if (w_finish) begin
                o_emit = 1'b1;
                if (!i_state.upper_half) begin
                    // save the lower result and start the upper half
                    n_st.lower_value     = n_st.best_value;
                    n_st.lower_deviation = n_st.best_deviation;
                    n_st.upper_half      = 1'b1;
                    n_st.trial_base      = C_UPPER_BASE;
                    n_st.step_size       = C_STEP_INIT;
                    n_st.phase           = PH_BINARY;
                    o_trim_value         = C_UPPER_BASE + C_STEP_INIT;
                end else begin
                    // pick upper only if nonzero and strictly better
                    if (n_st.best_value != 8'd0 &&
                        n_st.best_deviation < n_st.lower_deviation) begin
                        o_trim_value = n_st.best_value;
                    end else begin
                        o_trim_value = n_st.lower_value;
                    end
                    n_st.best_value = o_trim_value;
                    n_st.phase      = PH_DONE;
                    o_finished      = 1'b1;
                end
            end
        end
    end

    assign o_state = n_st;

endmodule

// ===== src/rc_oscillator_calibrator.sv =====
// ----------------------------------------------------------------------------
// rc_oscillator_calibrator: successive approximation trim search
// Answers each measurement during a search with the next oscillator trim to try
// and reports the final choice once both halves are searched.
//
//   channel   direction  handshake                       payload
//   input     in         i_in_valid / o_in_stall         i_action, i_frame_length
//   result    out        o_out_valid / i_out_stall       o_trim_value, o_finished
//   config    in         psel, penable, pwrite, pready   paddr, pwdata, prdata
//
// A transaction is registered on entry and then processed by the search logic into the
// result register; one transaction per cycle sustained while the result is not stalled.
// A single step of search logic lies between the two registers.
// A result waiting under stall leaves room for one more input transaction.
// Reset is synchronous and active low; it returns the search to idle and
// restores the target length.
// ----------------------------------------------------------------------------
module rc_oscillator_calibrator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_action,
    input  logic [15:0] i_frame_length,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_trim_value,
    output logic        o_finished,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rcc_pkg::*;

    logic        r_in_valid;
    logic        r_in_action;
    logic [15:0] r_in_frame;
    logic        r_out_valid;
    logic [7:0]  r_out_trim;
    logic        r_out_fin;
    logic [15:0] r_target;
    t_state      r_state;
    t_state      n_state;
    logic        w_emit;
    logic [7:0]  w_trim;
    logic        w_fin;
    logic        w_advance;
    logic        w_accept;
    logic        w_cfg_wr;

    // configuration register
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign prdata   = (paddr[2] == REG_TARGET) ? {16'd0, r_target} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= C_TARGET_RESET;
        end else if (w_cfg_wr && paddr[2] == REG_TARGET) begin
            r_target <= pwdata[15:0];
        end
    end

    // advance when the result register is free or being drained
    assign w_advance  = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_advance;
    assign w_accept   = i_in_valid && !o_in_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_action <= i_action;
            r_in_frame  <= i_frame_length;
        end
    end

    rcc_step u_step (
        .i_state        (r_state),
        .i_action       (r_in_action),
        .i_frame_length (r_in_frame),
        .i_target       (r_target),
        .o_state        (n_state),
        .o_emit         (w_emit),
        .o_trim_value   (w_trim),
        .o_finished     (w_fin)
    );

    // search state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: PH_IDLE, default: '0};
        end else if (w_advance) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_emit;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_emit) begin
            r_out_trim <= w_trim;
            r_out_fin  <= w_fin;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_trim_value = r_out_trim;
    assign o_finished   = r_out_fin;

    // a finished result always stems from the done phase
    a_fin_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_fin) |-> (r_state.phase == PH_DONE))
        else $error("finished result outside done phase");

    // binary search step stays a single power of two
    a_step_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == PH_BINARY) |-> $onehot(r_state.step_size))
        else $error("binary step is not a power of two");

    // neighbour trial never passes base plus one
    a_nb_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == PH_NEIGH) |->
            (r_state.neighbour_value <= {1'b0, r_state.trial_base} + 9'd1))
        else $error("neighbour trial out of range");

    // a held result is not overwritten
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_out_trim)))
        else $error("stalled result changed");

endmodule
